/* design/md5sh_pkg.sv */
// Shared types, constants and round tables of the MD5 stream hasher.
// Depends on nothing; used by md5sh_core and md5_stream_hasher_unit.
package md5sh_pkg;

  localparam int unsigned BufWords   = 16;
  localparam int unsigned BufAddrW   = 4;
  localparam logic [31:0] IvA        = 32'h67452301;
  localparam logic [31:0] IvB        = 32'hefcdab89;
  localparam logic [31:0] IvC        = 32'h98badcfe;
  localparam logic [31:0] IvD        = 32'h10325476;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam logic [5:0]  LenOffset  = 6'd56;
  localparam logic [5:0]  BlockLast  = 6'd63;
  localparam logic [5:0]  RoundLast  = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic       init_work;
    logic       round_en;
    logic [5:0] rnd;
    logic       fold;
    logic       restart;
  } core_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {round group, round mod 4}.
  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index used by a round.
  function automatic logic [BufAddrW-1:0] round_g(input logic [5:0] r);
    logic [BufAddrW-1:0] rl;
    logic [BufAddrW-1:0] g;
    rl = r[BufAddrW-1:0];
    unique case (r[5:4])
      2'd0: g = rl;
      2'd1: g = BufAddrW'({rl, 2'b00} + rl + 4'd1);
      2'd2: g = BufAddrW'({rl, 1'b0} + rl + 4'd5);
      2'd3: g = BufAddrW'({rl, 3'b000} - rl);
      default: g = rl;
    endcase
    return g;
  endfunction

endpackage

/* design/md5sh_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
// Stands alone; holds the message block buffer of the hasher.
module md5sh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/md5sh_core.sv */
// MD5 round datapath: chaining words, working words and one shared round unit.
// Depends on md5sh_pkg for control struct and round tables.
module md5sh_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  md5sh_pkg::core_ctl_t  ctl,
  input  logic [31:0]           msg_word,
  output logic [31:0]           chain0,
  output logic [31:0]           chain1,
  output logic [31:0]           chain2,
  output logic [31:0]           chain3
);

  logic [31:0] ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f_val, t_val, rot_val;
  logic [63:0] rot_wide;

  always_comb begin
    unique case (ctl.rnd[5:4])
      2'd0: f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1: f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2: f_val = b_r ^ c_r ^ d_r;
      2'd3: f_val = c_r ^ (b_r | ~d_r);
      default: f_val = '0;
    endcase
    t_val    = f_val + a_r + md5sh_pkg::round_k(ctl.rnd) + msg_word;
    rot_wide = {t_val, t_val} << md5sh_pkg::round_s(ctl.rnd);
    rot_val  = rot_wide[63:32];
  end

  // Working words: load from chain, then advance one round per enabled cycle.
  always_ff @(posedge clk) begin
    if (ctl.init_work) begin
      a_r <= ch_a_r;
      b_r <= ch_b_r;
      c_r <= ch_c_r;
      d_r <= ch_d_r;
    end else if (ctl.round_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      ch_a_r <= md5sh_pkg::IvA;
      ch_b_r <= md5sh_pkg::IvB;
      ch_c_r <= md5sh_pkg::IvC;
      ch_d_r <= md5sh_pkg::IvD;
    end else if (ctl.fold) begin
      ch_a_r <= ch_a_r + a_r;
      ch_b_r <= ch_b_r + b_r;
      ch_c_r <= ch_c_r + c_r;
      ch_d_r <= ch_d_r + d_r;
    end
  end

  assign chain0 = ch_a_r;
  assign chain1 = ch_b_r;
  assign chain2 = ch_c_r;
  assign chain3 = ch_d_r;

endmodule

/* design/md5_stream_hasher_unit.sv */
// Top level of the MD5 stream hasher: byte packer, padding sequencer, digest out.
// Depends on md5sh_pkg, md5sh_ram and md5sh_core.
//
//  channel | signals                                               | direction
//  --------+-------------------------------------------------------+------------
//  in      | in_valid in_ready in_data_byte in_byte_valid in_last  | input beat
//  out     | out_valid out_ready out_digest_word out_word_index    | result beat
//
// The out row also carries out_last_word.
//
// Every 64th byte starts a compression: a prefetch of the first message
// word from the buffer RAM, 64 rounds through the single round unit (one
// round per cycle), and a fold step. A last beat then pushes padding bytes
// one per cycle outside compressions (0x80, zeros up to offset 56, a pause
// without a push, then eight length bytes), with one or two compressions,
// and emits four digest beats. in_ready is high only while idle; out_valid
// holds each digest word until out_ready. Reset (rst_n low, synchronous)
// restores the initial chaining words and clears the fill index and bit
// count.
module md5_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  md5sh_pkg::seq_state_t state_r, state_nxt;
  md5sh_pkg::seq_state_t ret_r, ret_nxt;
  md5sh_pkg::core_ctl_t  ctl;

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [23:0] pack_r, pack_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        push;
  logic [7:0]  push_byte;
  logic        buf_we;
  logic [31:0] buf_wdata;
  logic [md5sh_pkg::BufAddrW-1:0] buf_raddr;
  logic [31:0] buf_rdata;
  logic [31:0] chain0, chain1, chain2, chain3;

  md5sh_ram #(
    .WIDTH(32),
    .DEPTH(md5sh_pkg::BufWords)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (fill_r[5:2]),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  md5sh_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .msg_word (buf_rdata),
    .chain0   (chain0),
    .chain1   (chain1),
    .chain2   (chain2),
    .chain3   (chain3)
  );

  // Pack bytes little-endian; write a whole word on every fourth byte.
  assign buf_we    = push && (fill_r[1:0] == 2'd3);
  assign buf_wdata = {push_byte, pack_r};

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    rnd_nxt     = rnd_r;
    len_cnt_nxt = len_cnt_r;
    idx_nxt     = idx_r;
    bits_nxt    = bits_r;
    push        = 1'b0;
    push_byte   = '0;
    buf_raddr   = md5sh_pkg::round_g(rnd_r + 6'd1);
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl         = '0;
    ctl.rnd     = rnd_r;

    unique case (state_r)
      md5sh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_valid) begin
            push      = 1'b1;
            push_byte = in_data_byte;
            bits_nxt  = bits_r + 64'd8;
          end
          if (in_byte_valid && (fill_r == md5sh_pkg::BlockLast)) begin
            state_nxt = md5sh_pkg::ST_LOAD;
            ret_nxt   = in_last ? md5sh_pkg::ST_MARK : md5sh_pkg::ST_IDLE;
          end else if (in_last) begin
            state_nxt = md5sh_pkg::ST_MARK;
          end
        end
      end
      md5sh_pkg::ST_MARK: begin
        push        = 1'b1;
        push_byte   = md5sh_pkg::PadMark;
        len_cnt_nxt = '0;
        if (fill_r == md5sh_pkg::BlockLast) begin
          state_nxt = md5sh_pkg::ST_LOAD;
          ret_nxt   = md5sh_pkg::ST_ZERO;
        end else begin
          state_nxt = md5sh_pkg::ST_ZERO;
        end
      end
      md5sh_pkg::ST_ZERO: begin
        if (fill_r == md5sh_pkg::LenOffset) begin
          state_nxt = md5sh_pkg::ST_LEN;
        end else begin
          push = 1'b1;
          if (fill_r == md5sh_pkg::BlockLast) begin
            state_nxt = md5sh_pkg::ST_LOAD;
            ret_nxt   = md5sh_pkg::ST_ZERO;
          end
        end
      end
      md5sh_pkg::ST_LEN: begin
        // Length bytes go out least significant first.
        push        = 1'b1;
        push_byte   = bits_r[{len_cnt_r, 3'b000} +: 8];
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (fill_r == md5sh_pkg::BlockLast) begin
          state_nxt = md5sh_pkg::ST_LOAD;
          ret_nxt   = md5sh_pkg::ST_EMIT;
        end
      end
      md5sh_pkg::ST_LOAD: begin
        // Prefetch the first round's word while loading the working words.
        ctl.init_work = 1'b1;
        buf_raddr     = md5sh_pkg::round_g(6'd0);
        rnd_nxt       = '0;
        state_nxt     = md5sh_pkg::ST_ROUND;
      end
      md5sh_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == md5sh_pkg::RoundLast) begin
          state_nxt = md5sh_pkg::ST_FOLD;
        end
      end
      md5sh_pkg::ST_FOLD: begin
        ctl.fold  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ret_r;
      end
      md5sh_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            // Drop back to the initial chain for the next message.
            ctl.restart = 1'b1;
            bits_nxt    = '0;
            state_nxt   = md5sh_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = md5sh_pkg::ST_IDLE;
    endcase

    fill_nxt = push ? fill_r + 6'd1 : fill_r;
    pack_nxt = push ? {push_byte, pack_r[23:8]} : pack_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= md5sh_pkg::ST_IDLE;
      ret_r     <= md5sh_pkg::ST_IDLE;
      fill_r    <= '0;
      bits_r    <= '0;
      rnd_r     <= '0;
      len_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      rnd_r     <= rnd_nxt;
      len_cnt_r <= len_cnt_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
  end

  always_comb begin
    unique case (idx_r)
      2'd0: out_digest_word = chain0;
      2'd1: out_digest_word = chain1;
      2'd2: out_digest_word = chain2;
      2'd3: out_digest_word = chain3;
      default: out_digest_word = chain0;
    endcase
  end

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 2'd3);

endmodule
